FILE: src/rrfp_pkg.sv
// Shared constants, types and control/status structs for the radar report frame parser.
// No dependencies; imported by every module of the block except rrfp_ram.
package rrfp_pkg;

  localparam int GATE_COUNT  = 14;
  localparam int MAX_PAYLOAD = 128;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int BASIC_LEN   = 11;
  localparam int ENG_LEN     = BASIC_LEN + 2 + 2 * GATE_COUNT;
  localparam int SLOT_COUNT  = BASIC_LEN + 1;  // payload bytes 0..10 plus end marker

  localparam logic [31:0] HEADER_WORD = 32'hF4F3F2F1;
  localparam logic [7:0]  TAIL_0      = 8'hF8;
  localparam logic [7:0]  TAIL_1      = 8'hF7;
  localparam logic [7:0]  TAIL_2      = 8'hF6;
  localparam logic [7:0]  TAIL_3      = 8'hF5;
  localparam logic [7:0]  MARK_HEAD   = 8'hAA;
  localparam logic [7:0]  MARK_END    = 8'h55;
  localparam logic [7:0]  TYPE_ENG    = 8'h01;
  localparam logic [7:0]  TYPE_BASIC  = 8'h02;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MARKERS   = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_ENG_SHORT = 3'd4
  } frame_status_t;

  typedef enum logic [1:0] {
    RD_SUM = 2'd0,
    RD_MOV = 2'd1,
    RD_STA = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    clr_hunt;
    logic    shift_win;
    logic    ld_len_lo;
    logic    ld_len;
    logic    wr_payload;
    logic    tail_inc;
    logic    fetch_clear;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_sum;
    logic    cap_mov;
    logic    ld_sum;
    logic    ld_gate;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic len_ok;
    logic len_zero;
    logic pay_done;
    logic tail_ok;
    logic tail_last;
    logic len_short;
    logic sum_last;
    logic eng_ok;
    logic gate_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/rrfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rrfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/rrfp_datapath.sv
// Datapath: hunt window, length and count registers, payload RAM, decode slots
// and the result register. Depends on rrfp_pkg and rrfp_ram.
module rrfp_datapath
  import rrfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  sts,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        engineering,
  output logic [7:0]  target_state,
  output logic [15:0] moving_distance,
  output logic [7:0]  move_energy,
  output logic [15:0] static_distance,
  output logic [7:0]  still_energy,
  output logic [7:0]  top_move_gate,
  output logic [7:0]  top_still_gate,
  output logic [4:0]  gate_number,
  output logic        is_gate,
  output logic        last
);

  logic [31:0]       hunt_window;
  logic [7:0]        length_low;
  logic [7:0]        payload_length;
  logic [7:0]        byte_count;
  logic [3:0]        sum_idx;
  logic [4:0]        gate_idx;
  logic [7:0]        slot [SLOT_COUNT];
  logic [7:0]        gate_mov;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        tail_ref;
  logic [31:0]       win_next;
  logic [8:0]        count_inc;
  frame_status_t     sum_status;
  logic              sum_eng;
  logic              sum_fill;

  assign win_next  = {hunt_window[23:0], rx_byte};
  assign count_inc = {1'b0, byte_count} + 9'd1;

  always_comb begin
    unique case (byte_count[1:0])
      2'd0:    tail_ref = TAIL_0;
      2'd1:    tail_ref = TAIL_1;
      2'd2:    tail_ref = TAIL_2;
      default: tail_ref = TAIL_3;
    endcase
  end

  // read address for decode fetches; slot 11 holds the byte before the last
  always_comb begin
    unique case (cmd.rd_sel)
      RD_SUM: begin
        if (sum_idx == 4'(BASIC_LEN)) begin
          rd_addr = ADDR_W'(payload_length - 8'd2);
        end else begin
          rd_addr = ADDR_W'(sum_idx);
        end
      end
      RD_MOV:  rd_addr = ADDR_W'(BASIC_LEN) + ADDR_W'(gate_idx);
      RD_STA:  rd_addr = ADDR_W'(BASIC_LEN + GATE_COUNT) + ADDR_W'(gate_idx);
      default: rd_addr = '0;
    endcase
  end

  rrfp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_payload),
    .wr_addr (ADDR_W'(byte_count)),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // summary classification from the captured slots
  always_comb begin
    sum_eng  = 1'b0;
    sum_fill = 1'b1;
    priority if (payload_length < 8'(BASIC_LEN)) begin
      sum_status = ST_SHORT;
      sum_fill   = 1'b0;
    end else if (slot[1] != MARK_HEAD || slot[BASIC_LEN] != MARK_END) begin
      sum_status = ST_MARKERS;
      sum_fill   = 1'b0;
    end else if (slot[0] == TYPE_BASIC) begin
      sum_status = ST_OK;
    end else if (slot[0] != TYPE_ENG) begin
      sum_status = ST_UNKNOWN;
    end else if (payload_length < 8'(ENG_LEN)) begin
      sum_status = ST_ENG_SHORT;
    end else begin
      sum_status = ST_OK;
      sum_eng    = 1'b1;
    end
  end

  always_comb begin
    sts.hdr_match = (win_next == HEADER_WORD);
    sts.len_ok    = ({rx_byte, length_low} <= 16'(MAX_PAYLOAD));
    sts.len_zero  = (length_low == 8'd0);
    sts.pay_done  = (count_inc >= {1'b0, payload_length});
    sts.tail_ok   = (rx_byte == tail_ref);
    sts.tail_last = (byte_count[1:0] == 2'd3);
    sts.len_short = (payload_length < 8'(BASIC_LEN));
    sts.sum_last  = (sum_idx == 4'(BASIC_LEN));
    sts.eng_ok    = sum_eng;
    sts.gate_last = (gate_idx == 5'(GATE_COUNT - 1));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_window    <= '0;
      length_low     <= '0;
      payload_length <= '0;
      byte_count     <= '0;
      sum_idx        <= '0;
      gate_idx       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.clr_hunt) begin
        hunt_window <= '0;
        byte_count  <= '0;
      end else if (cmd.shift_win) begin
        hunt_window <= win_next;
      end
      if (cmd.ld_len_lo) begin
        length_low <= rx_byte;
      end
      if (cmd.ld_len) begin
        payload_length <= length_low;
        byte_count     <= '0;
      end
      if (cmd.wr_payload) begin
        byte_count <= sts.pay_done ? 8'd0 : count_inc[7:0];
      end
      if (cmd.tail_inc) begin
        byte_count <= count_inc[7:0];
      end
      if (cmd.fetch_clear) begin
        sum_idx  <= '0;
        gate_idx <= '0;
      end else if (cmd.cap_sum) begin
        sum_idx <= sum_idx + 4'd1;
      end else if (cmd.ld_gate) begin
        gate_idx <= gate_idx + 5'd1;
      end
      if (cmd.ld_sum || cmd.ld_gate) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_sum) begin
      slot[sum_idx] <= rd_data;
    end
    if (cmd.cap_mov) begin
      gate_mov <= rd_data;
    end
    if (cmd.ld_sum) begin
      status          <= sum_status;
      engineering     <= sum_eng;
      target_state    <= sum_fill ? slot[2] : 8'd0;
      moving_distance <= sum_fill ? {slot[4], slot[3]} : 16'd0;
      move_energy     <= sum_fill ? slot[5] : 8'd0;
      static_distance <= sum_fill ? {slot[7], slot[6]} : 16'd0;
      still_energy    <= sum_fill ? slot[8] : 8'd0;
      top_move_gate   <= sum_eng ? slot[9] : 8'd0;
      top_still_gate  <= sum_eng ? slot[10] : 8'd0;
      gate_number     <= '0;
      is_gate         <= 1'b0;
      last            <= !sum_eng;
    end else if (cmd.ld_gate) begin
      status          <= ST_OK;
      engineering     <= 1'b1;
      target_state    <= '0;
      moving_distance <= '0;
      move_energy     <= gate_mov;
      static_distance <= '0;
      still_energy    <= rd_data;
      top_move_gate   <= '0;
      top_still_gate  <= '0;
      gate_number     <= gate_idx;
      is_gate         <= 1'b1;
      last            <= sts.gate_last;
    end
  end

endmodule

FILE: src/rrfp_ctrl.sv
// Controller FSM: frame phase tracking and decode/result sequencing.
// Depends on rrfp_pkg; drives rrfp_datapath through dp_cmd_t.
module rrfp_ctrl
  import rrfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       flush,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [12:0] {
    S_HUNT    = 13'b0000000000001,
    S_LEN_LO  = 13'b0000000000010,
    S_LEN_HI  = 13'b0000000000100,
    S_PAYLOAD = 13'b0000000001000,
    S_TAIL    = 13'b0000000010000,
    S_RD      = 13'b0000000100000,
    S_CAP     = 13'b0000001000000,
    S_SUM     = 13'b0000010000000,
    S_GRD_M   = 13'b0000100000000,
    S_GRD_S   = 13'b0001000000000,
    S_GOUT    = 13'b0010000000000,
    S_UNUSED0 = 13'b0100000000000,
    S_UNUSED1 = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_HUNT) || (state == S_LEN_LO) || (state == S_LEN_HI) ||
                    (state == S_PAYLOAD) || (state == S_TAIL);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_SUM;
    state_next = state;
    unique case (state)
      S_HUNT: begin
        if (accept) begin
          if (flush) begin
            cmd.clr_hunt = 1'b1;
          end else if (sts.hdr_match) begin
            cmd.clr_hunt = 1'b1;
            state_next   = S_LEN_LO;
          end else begin
            cmd.shift_win = 1'b1;
          end
        end
      end
      S_LEN_LO: begin
        if (accept) begin
          if (flush) begin
            cmd.clr_hunt = 1'b1;
            state_next   = S_HUNT;
          end else begin
            cmd.ld_len_lo = 1'b1;
            state_next    = S_LEN_HI;
          end
        end
      end
      S_LEN_HI: begin
        if (accept) begin
          if (flush || !sts.len_ok) begin
            cmd.clr_hunt = 1'b1;
            state_next   = S_HUNT;
          end else begin
            cmd.ld_len = 1'b1;
            state_next = sts.len_zero ? S_TAIL : S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (accept) begin
          if (flush) begin
            cmd.clr_hunt = 1'b1;
            state_next   = S_HUNT;
          end else begin
            cmd.wr_payload = 1'b1;
            if (sts.pay_done) begin
              state_next = S_TAIL;
            end
          end
        end
      end
      S_TAIL: begin
        if (accept) begin
          if (flush || !sts.tail_ok) begin
            cmd.clr_hunt = 1'b1;
            state_next   = S_HUNT;
          end else if (sts.tail_last) begin
            cmd.clr_hunt    = 1'b1;
            cmd.fetch_clear = 1'b1;
            state_next      = sts.len_short ? S_SUM : S_RD;
          end else begin
            cmd.tail_inc = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SUM;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap_sum = 1'b1;
        state_next  = sts.sum_last ? S_SUM : S_RD;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.ld_sum = 1'b1;
          state_next = sts.eng_ok ? S_GRD_M : S_HUNT;
        end
      end
      S_GRD_M: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_MOV;
        state_next = S_GRD_S;
      end
      S_GRD_S: begin
        cmd.cap_mov = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_STA;
        state_next  = S_GOUT;
      end
      S_GOUT: begin
        cmd.rd_sel = RD_STA;
        if (sts.out_free) begin
          cmd.ld_gate = 1'b1;
          state_next  = sts.gate_last ? S_HUNT : S_GRD_M;
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/radar_report_frame_parser.sv
// Radar report frame parser top: rrfp_ctrl plus rrfp_datapath (holds rrfp_ram), uses rrfp_pkg.
// Throughput: one byte per cycle while framing; input stalls through the decode burst.
// Decode: the summary request follows 12 RAM fetches after the last tail byte (none for a
// payload under 11 bytes); each gate request follows a moving and a static energy fetch.
// A busy result register holds the sequence until it frees up.
// Reset: rst (sync, active high) -> header hunt, clear window/counters, no pending result.
module radar_report_frame_parser
  import rrfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        flush,
  // result request channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        engineering,
  output logic [7:0]  target_state,
  output logic [15:0] moving_distance,
  output logic [7:0]  move_energy,
  output logic [15:0] static_distance,
  output logic [7:0]  still_energy,
  output logic [7:0]  top_move_gate,
  output logic [7:0]  top_still_gate,
  output logic [4:0]  gate_number,
  output logic        is_gate,
  output logic        last
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  // controller owns the frame phase; it only accepts bytes while framing
  rrfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flush    (flush),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds every counter, the payload store and the result register,
  // so a finished result can wait while the next frame's bytes come in
  rrfp_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .engineering     (engineering),
    .target_state    (target_state),
    .moving_distance (moving_distance),
    .move_energy     (move_energy),
    .static_distance (static_distance),
    .still_energy    (still_energy),
    .top_move_gate   (top_move_gate),
    .top_still_gate  (top_still_gate),
    .gate_number     (gate_number),
    .is_gate         (is_gate),
    .last            (last)
  );

endmodule
